// File: rtl/vll_pkg.sv
package vll_pkg;

    localparam int unsigned REG_W      = 48;
    localparam int unsigned FIELD_W    = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned SQRT_STEPS = 31;
    localparam int unsigned DIV_STEPS  = 20;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIGHT_DIRECTION = 3'd0,
        REG_LIGHT_COLOR     = 3'd1,
        REG_AMBIENT_COLOR   = 3'd2,
        REG_DIFFUSE_COLOR   = 3'd3,
        REG_NORMAL_ROW_X    = 3'd4,
        REG_NORMAL_ROW_Y    = 3'd5,
        REG_NORMAL_ROW_Z    = 3'd6
    } cfg_reg_t;

    localparam logic [REG_W-1:0] RST_LIGHT_DIRECTION = 48'h0000_0000_0000;
    localparam logic [REG_W-1:0] RST_LIGHT_COLOR     = 48'h4000_4000_4000;
    localparam logic [REG_W-1:0] RST_AMBIENT_COLOR   = 48'h0000_0000_0000;
    localparam logic [REG_W-1:0] RST_DIFFUSE_COLOR   = 48'h4000_4000_4000;
    localparam logic [REG_W-1:0] RST_NORMAL_ROW_X    = 48'h1000_0000_0000;
    localparam logic [REG_W-1:0] RST_NORMAL_ROW_Y    = 48'h0000_1000_0000;
    localparam logic [REG_W-1:0] RST_NORMAL_ROW_Z    = 48'h0000_0000_1000;

    // field k of a packed register: 0 = bits 47:32, 1 = 31:16, 2 = 15:0
    function automatic logic signed [FIELD_W-1:0] get_part(input logic [REG_W-1:0] r,
                                                           input int unsigned k);
        logic signed [FIELD_W-1:0] f;
        f = $signed(r[(2-k)*FIELD_W +: FIELD_W]);
        return f;
    endfunction

endpackage

// File: rtl/vertex_lambert_lighting.sv
// Per-vertex Lambert diffuse lighting.
//
// Input channel (in_valid / in_ready): one model-space normal per request,
// normal_x/y/z signed Q2.14. Output channel (out_valid / out_ready): one
// packed ARGB colour per request (alpha 0xFF) and zero_normal, set when the
// transformed normal has zero length and only ambient light is applied.
// Configuration: cfg_write with cfg_index and cfg_data writes one of seven
// 48-bit registers at once; unknown indexes are dropped. Write only while
// the block is empty.
//
// Throughput is one request per cycle unless the receiver stalls. A request
// passes four stages of matrix transform, squares and dot product, 31
// stages of the square-root recurrence (one root bit each), one setup
// stage, 20 stages of restoring division for the cosine (one quotient bit
// each), three colour stages and the output register before out_valid.
//
// Reset clears every valid bit and loads the register defaults (white
// light and material, identity matrix, zero light direction). When the
// receiver stalls the pipeline keeps filling until its last stage holds a
// finished request behind the waiting output; then all stages hold and
// in_ready drops. No request is lost or repeated.
module vertex_lambert_lighting
    import vll_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       cfg_write,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [REG_W-1:0]           cfg_data,

    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [FIELD_W-1:0]  normal_x,
    input  logic signed [FIELD_W-1:0]  normal_y,
    input  logic signed [FIELD_W-1:0]  normal_z,

    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [31:0]                vertex_color,
    output logic                       zero_normal
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [REG_W-1:0] light_dir_reg, light_col_reg, ambient_reg, diffuse_reg;
    logic [REG_W-1:0] row_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_dir_reg <= RST_LIGHT_DIRECTION;
            light_col_reg <= RST_LIGHT_COLOR;
            ambient_reg   <= RST_AMBIENT_COLOR;
            diffuse_reg   <= RST_DIFFUSE_COLOR;
            row_reg[0]    <= RST_NORMAL_ROW_X;
            row_reg[1]    <= RST_NORMAL_ROW_Y;
            row_reg[2]    <= RST_NORMAL_ROW_Z;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LIGHT_DIRECTION: light_dir_reg <= cfg_data;
                REG_LIGHT_COLOR:     light_col_reg <= cfg_data;
                REG_AMBIENT_COLOR:   ambient_reg   <= cfg_data;
                REG_DIFFUSE_COLOR:   diffuse_reg   <= cfg_data;
                REG_NORMAL_ROW_X:    row_reg[0]    <= cfg_data;
                REG_NORMAL_ROW_Y:    row_reg[1]    <= cfg_data;
                REG_NORMAL_ROW_Z:    row_reg[2]    <= cfg_data;
                default:             ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Global advance: hold everything only when the last stage is full
    // and the output register cannot take it.
    // ---------------------------------------------------------------
    logic en;
    logic c_v_reg;

    assign en       = !c_v_reg || !out_valid || out_ready;
    assign in_ready = en;

    logic signed [FIELD_W-1:0] n_in [3];
    assign n_in[0] = normal_x;
    assign n_in[1] = normal_y;
    assign n_in[2] = normal_z;

    // ---------------------------------------------------------------
    // Stage 1: nine matrix products, Q.26
    // ---------------------------------------------------------------
    logic               v1_reg;
    logic signed [31:0] mp_reg [3][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    mp_reg[i][j] <= get_part(row_reg[i], j) * n_in[j];
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: row sums, then divide by four rounding down (Q.24)
    // ---------------------------------------------------------------
    logic               v2_reg;
    logic signed [30:0] s_reg [3];
    logic signed [33:0] t_sum [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            t_sum[i] = 34'(mp_reg[i][0]) + 34'(mp_reg[i][1]) + 34'(mp_reg[i][2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                s_reg[i] <= t_sum[i][32:2];
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: squares and light products
    // ---------------------------------------------------------------
    logic               v3_reg;
    logic [59:0]        sqr_reg [3];
    logic signed [46:0] ld_reg  [3];
    logic signed [61:0] sqr_full [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            sqr_full[i] = s_reg[i] * s_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sqr_reg[i] <= sqr_full[i][59:0];
                ld_reg[i]  <= get_part(light_dir_reg, i) * s_reg[i];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 4 feeds the root recurrence: squared length and dot product
    // ---------------------------------------------------------------
    logic [60:0]        sq_rem_reg [SQRT_STEPS+1];
    logic [60:0]        sq_res_reg [SQRT_STEPS+1];
    logic signed [48:0] sq_dot_reg [SQRT_STEPS+1];
    logic [SQRT_STEPS:0] sq_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_v_reg[0] <= 1'b0;
        else if (en)
            sq_v_reg[0] <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_rem_reg[0] <= 61'(sqr_reg[0]) + 61'(sqr_reg[1]) + 61'(sqr_reg[2]);
            sq_res_reg[0] <= '0;
            sq_dot_reg[0] <= 49'(ld_reg[0]) + 49'(ld_reg[1]) + 49'(ld_reg[2]);
        end
    end

    // ---------------------------------------------------------------
    // Integer square root, one root bit per stage
    // ---------------------------------------------------------------
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        localparam logic [61:0] STEP_BIT = 62'(1) << (2 * (SQRT_STEPS - 1 - k));
        logic [61:0] trial;
        logic        take;

        assign trial = 62'(sq_res_reg[k]) + STEP_BIT;
        assign take  = 62'(sq_rem_reg[k]) >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_v_reg[k+1] <= 1'b0;
            else if (en)
                sq_v_reg[k+1] <= sq_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_dot_reg[k+1] <= sq_dot_reg[k];
                if (take)
                begin
                    sq_rem_reg[k+1] <= sq_rem_reg[k] - trial[60:0];
                    sq_res_reg[k+1] <= (sq_res_reg[k] >> 1) + STEP_BIT[60:0];
                end
                else
                begin
                    sq_rem_reg[k+1] <= sq_rem_reg[k];
                    sq_res_reg[k+1] <= sq_res_reg[k] >> 1;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Division setup: numerator dot*4 + len/2, zeroed for no diffuse
    // ---------------------------------------------------------------
    logic [30:0] len_w;
    logic        len_zero;
    logic        lit;

    assign len_w    = sq_res_reg[SQRT_STEPS][30:0];
    assign len_zero = (len_w == '0);
    assign lit      = !len_zero && (sq_dot_reg[SQRT_STEPS] > 0);

    logic [50:0]         dv_rem_reg  [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] dv_q_reg   [DIV_STEPS+1];
    logic [30:0]         dv_len_reg  [DIV_STEPS+1];
    logic [DIV_STEPS:0]  dv_zero_reg;
    logic [DIV_STEPS:0]  dv_lit_reg;
    logic [DIV_STEPS:0]  dv_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_v_reg[0] <= 1'b0;
        else if (en)
            dv_v_reg[0] <= sq_v_reg[SQRT_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_rem_reg[0]  <= lit ? ({sq_dot_reg[SQRT_STEPS][48:0], 2'b00}
                                     + 51'(len_w >> 1)) : '0;
            dv_q_reg[0]    <= '0;
            dv_len_reg[0]  <= len_w;
            dv_zero_reg[0] <= len_zero;
            dv_lit_reg[0]  <= lit;
        end
    end

    // ---------------------------------------------------------------
    // Restoring division for the cosine, one quotient bit per stage
    // ---------------------------------------------------------------
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        localparam int unsigned QB = DIV_STEPS - 1 - i;
        logic [50:0] dshift;
        logic        take;

        assign dshift = 51'(dv_len_reg[i]) << QB;
        assign take   = dv_rem_reg[i] >= dshift;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v_reg[i+1] <= 1'b0;
            else if (en)
                dv_v_reg[i+1] <= dv_v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_len_reg[i+1]  <= dv_len_reg[i];
                dv_zero_reg[i+1] <= dv_zero_reg[i];
                dv_lit_reg[i+1]  <= dv_lit_reg[i];
                dv_rem_reg[i+1]  <= take ? (dv_rem_reg[i] - dshift) : dv_rem_reg[i];
                dv_q_reg[i+1]    <= dv_q_reg[i] | (take ? (DIV_STEPS'(1) << QB) : '0);
            end
        end
    end

    // ---------------------------------------------------------------
    // Colour stages
    // ---------------------------------------------------------------
    logic signed [31:0] prod_reg [3];

    // light times diffuse only changes with configuration
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
            prod_reg[k] <= get_part(light_col_reg, k) * get_part(diffuse_reg, k);
    end

    logic signed [20:0] cos_s;
    assign cos_s = dv_lit_reg[DIV_STEPS] ? $signed({1'b0, dv_q_reg[DIV_STEPS]}) : '0;

    logic               m_v_reg, m_zero_reg;
    logic signed [52:0] m_mul_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_v_reg <= 1'b0;
        else if (en)
            m_v_reg <= dv_v_reg[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_zero_reg <= dv_zero_reg[DIV_STEPS];
            for (int k = 0; k < 3; k++)
                m_mul_reg[k] <= prod_reg[k] * cos_s;
        end
    end

    // add ambient and clamp to 0..1.0 in Q.44
    logic               b_v_reg, b_zero_reg;
    logic [44:0]        b_c_reg [3];
    logic signed [53:0] b_sum [3];
    logic [44:0]        b_clamp [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            b_sum[k] = 54'(m_mul_reg[k]) + (54'(get_part(ambient_reg, k)) <<< 30);
            if (b_sum[k] < 0)
                b_clamp[k] = '0;
            else if (b_sum[k] > (54'(1) << 44))
                b_clamp[k] = 45'(1) << 44;
            else
                b_clamp[k] = b_sum[k][44:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_v_reg <= 1'b0;
        else if (en)
            b_v_reg <= m_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_zero_reg <= m_zero_reg;
            for (int k = 0; k < 3; k++)
                b_c_reg[k] <= b_clamp[k];
        end
    end

    // scale by 255 with rounding to nearest
    logic [51:0] scaled [3];
    logic [7:0]  chan   [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            scaled[k] = ({7'b0, b_c_reg[k]} << 8) - {7'b0, b_c_reg[k]} + (52'(1) << 43);
            chan[k]   = scaled[k][51:44];
        end
    end

    logic        c_zero_reg;
    logic [31:0] c_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_v_reg <= 1'b0;
        else if (en)
            c_v_reg <= b_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_zero_reg  <= b_zero_reg;
            c_color_reg <= {ALPHA_OPAQUE, chan[0], chan[1], chan[2]};
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    logic        out_valid_reg, out_zero_reg;
    logic [31:0] out_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en && c_v_reg)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (en && c_v_reg)
        begin
            out_zero_reg  <= c_zero_reg;
            out_color_reg <= c_color_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign vertex_color = out_color_reg;
    assign zero_normal  = out_zero_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> vertex_color[31:24] == ALPHA_OPAQUE)
        else $error("alpha byte of result is not opaque");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> v1_reg)
        else $error("accepted request did not enter the pipeline");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> $stable(dv_v_reg) && $stable(sq_v_reg))
        else $error("pipeline moved while held");

    a_lit_len: assert property (@(posedge clk) disable iff (!rst_n)
        dv_v_reg[0] && dv_lit_reg[0] |-> !dv_zero_reg[0])
        else $error("diffuse term enabled for a zero-length normal");

endmodule

// File: tb/vertex_lambert_lighting_checker.sv
`timescale 1ns / 1ps

module vertex_lambert_lighting_checker
    import vll_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [REG_W-1:0]           cfg_data,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic signed [FIELD_W-1:0]  normal_x,
    input  logic signed [FIELD_W-1:0]  normal_y,
    input  logic signed [FIELD_W-1:0]  normal_z,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [31:0]                vertex_color,
    input  logic                       zero_normal,
    output int                         fail_count,
    output int                         pending_colours
);

    typedef struct packed {
        logic [31:0] colour;
        logic        zero_len;
    } shade_t;

    logic [REG_W-1:0] light_dir, light_col, ambient, diffuse;
    logic [REG_W-1:0] mrow [3];
    shade_t           colour_q [$];

    function automatic longint fld(input logic [REG_W-1:0] r, input int k);
        logic signed [FIELD_W-1:0] f;
        f = r[(2-k)*FIELD_W +: FIELD_W];
        return longint'(f);
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [7:0] shade_channel(input int k, input longint unsigned cq);
        longint          c;
        longint unsigned u;
        c = fld(light_col, k) * fld(diffuse, k) * longint'(cq)
            + fld(ambient, k) * (64'sd1 <<< 30);
        if (c < 0)
            c = 0;
        if (c > (64'sd1 <<< 44))
            c = 64'sd1 <<< 44;
        u = longint'(c);
        return 8'((u * 255 + (64'd1 << 43)) >> 44);
    endfunction

    function automatic shade_t shade_vertex(input longint nx, input longint ny,
                                            input longint nz);
        longint          n [3];
        longint          t, s, dp;
        longint unsigned sq, len, cq;
        shade_t          r;
        n[0] = nx; n[1] = ny; n[2] = nz;
        dp = 0;
        sq = 0;
        cq = 0;
        for (int i = 0; i < 3; i++)
        begin
            t = 0;
            for (int j = 0; j < 3; j++)
                t += fld(mrow[i], j) * n[j];
            s = t >>> 2;              // arithmetic shift floors toward minus infinity
            sq += longint'(s * s);
            dp += fld(light_dir, i) * s;
        end
        len = root_floor(sq);
        if (len != 0 && dp > 0)
            cq = (longint'(dp) * 4 + len / 2) / len;
        r.colour   = {ALPHA_OPAQUE, shade_channel(0, cq), shade_channel(1, cq),
                      shade_channel(2, cq)};
        r.zero_len = (len == 0);
        return r;
    endfunction

    assign pending_colours = colour_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        shade_t exp_s;
        if (!rst_n)
        begin
            light_dir  <= RST_LIGHT_DIRECTION;
            light_col  <= RST_LIGHT_COLOR;
            ambient    <= RST_AMBIENT_COLOR;
            diffuse    <= RST_DIFFUSE_COLOR;
            mrow[0]    <= RST_NORMAL_ROW_X;
            mrow[1]    <= RST_NORMAL_ROW_Y;
            mrow[2]    <= RST_NORMAL_ROW_Z;
            fail_count <= 0;
            colour_q.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                colour_q.push_back(shade_vertex(normal_x, normal_y, normal_z));
            if (out_valid && out_ready)
            begin
                if (colour_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected colour %h zero %b", vertex_color, zero_normal);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_s = colour_q.pop_front();
                    if (exp_s.colour !== vertex_color || exp_s.zero_len !== zero_normal)
                    begin
                        if (fail_count < 10)
                            $display("mismatch colour exp %h got %h, zero exp %b got %b",
                                     exp_s.colour, vertex_color, exp_s.zero_len,
                                     zero_normal);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // registers take effect after the edge; the block is idle then anyway
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_LIGHT_DIRECTION: light_dir <= cfg_data;
                    REG_LIGHT_COLOR:     light_col <= cfg_data;
                    REG_AMBIENT_COLOR:   ambient   <= cfg_data;
                    REG_DIFFUSE_COLOR:   diffuse   <= cfg_data;
                    REG_NORMAL_ROW_X:    mrow[0]   <= cfg_data;
                    REG_NORMAL_ROW_Y:    mrow[1]   <= cfg_data;
                    REG_NORMAL_ROW_Z:    mrow[2]   <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: tb/vertex_lambert_lighting_tb.sv
`timescale 1ns / 1ps

module vertex_lambert_lighting_tb;
    import vll_pkg::*;

    localparam int LATENCY = 60;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [REG_W-1:0]          cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic signed [FIELD_W-1:0] normal_x, normal_y, normal_z;
    logic                      out_valid;
    logic                      out_ready;
    logic [31:0]               vertex_color;
    logic                      zero_normal;
    int                        fail_count;
    int                        pending_colours;
    bit                        calm;   // suppress idling on both sides

    vertex_lambert_lighting i_dut (.*);

    vertex_lambert_lighting_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver: stall at random with a chance of 37 in 100 unless a calm stretch is running.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= calm || ($urandom_range(99) >= 37);
        end
    end

    // Watchdog: worst case is well under this even with every gap and stall.
    initial
    begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Present one request; hold valid and payload until accepted.
    task automatic send_normal(input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] z);
        while (!calm && $urandom_range(99) < 37)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        normal_x <= x;
        normal_y <= y;
        normal_z <= z;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Drop valid, drain every expected colour, then let the pipe settle.
    task automatic drain;
        in_valid <= 1'b0;
        while (pending_colours != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [REG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [15:0] rand_field();
        case ($urandom_range(5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random triples with each field in -sc..sc; the callers sometimes use anything at all.
    function automatic logic [REG_W-1:0] rand_triple(input int sc);
        return {16'($signed($urandom_range(2*sc)) - sc),
                16'($signed($urandom_range(2*sc)) - sc),
                16'($signed($urandom_range(2*sc)) - sc)};
    endfunction

    initial
    begin
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        normal_x  = '0;
        normal_y  = '0;
        normal_z  = '0;
        calm      = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: zero normal and a unit axis with the reset light (zero), then axes and extremes.
        send_normal(16'h0000, 16'h0000, 16'h0000);
        send_normal(16'h4000, 16'h0000, 16'h0000);
        drain();
        write_reg(REG_LIGHT_DIRECTION, 48'h0000_0000_4000);
        write_reg(REG_AMBIENT_COLOR, 48'h0800_1000_0000);
        send_normal(16'h0000, 16'h0000, 16'h4000);
        send_normal(16'h0000, 16'h0000, 16'hC000);   // facing away: ambient only
        send_normal(16'h0000, 16'h0000, 16'h0000);   // zero length
        send_normal(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_normal(16'h8000, 16'h8000, 16'h8000);
        send_normal(16'h7FFF, 16'h8000, 16'h0001);
        send_normal(16'h0001, 16'h0000, 16'h0000);
        send_normal(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_normal(16'h2D41, 16'h0000, 16'h2D41);
        drain();
        // Extreme registers: negative colours, oversized light, full-range matrix.
        write_reg(REG_LIGHT_DIRECTION, 48'h7FFF_7FFF_7FFF);
        write_reg(REG_LIGHT_COLOR, 48'h7FFF_8000_FFFF);
        write_reg(REG_DIFFUSE_COLOR, 48'h7FFF_8000_4000);
        write_reg(REG_AMBIENT_COLOR, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_NORMAL_ROW_X, 48'h7FFF_8000_7FFF);
        write_reg(REG_NORMAL_ROW_Y, 48'h8000_7FFF_8000);
        write_reg(REG_NORMAL_ROW_Z, 48'hFFFF_0001_0000);
        cfg_write <= 1'b1;                 // unknown index: must be dropped
        cfg_index <= 3'd7;
        cfg_data  <= 48'h1234_5678_9ABC;
        @(negedge clk);
        cfg_write <= 1'b0;
        send_normal(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_normal(16'h8000, 16'h8000, 16'h8000);
        send_normal(16'h8000, 16'h7FFF, 16'h0000);
        send_normal(16'h0000, 16'h0000, 16'h0000);
        send_normal(16'h1234, 16'hEDCB, 16'h4000);
        drain();
        // Singular matrix: every normal collapses to zero length.
        write_reg(REG_NORMAL_ROW_X, 48'h0);
        write_reg(REG_NORMAL_ROW_Y, 48'h0);
        write_reg(REG_NORMAL_ROW_Z, 48'h0);
        send_normal(16'h4000, 16'h4000, 16'h4000);
        send_normal(16'h8000, 16'h7FFF, 16'h0001);
        drain();

        // Random phases; the first runs calm, one more pauses mid-phase.
        for (int ph = 0; ph < 15; ph++)
        begin
            write_reg(REG_LIGHT_DIRECTION, ($urandom_range(3) == 0)
                                           ? 48'({$urandom, $urandom})
                                           : rand_triple(16384));
            write_reg(REG_LIGHT_COLOR, ($urandom_range(4) == 0)
                                       ? 48'({$urandom, $urandom})
                                       : rand_triple(16384) ^ 48'h0);
            write_reg(REG_AMBIENT_COLOR, ($urandom_range(3) == 0)
                                         ? 48'({$urandom, $urandom})
                                         : rand_triple(4096));
            write_reg(REG_DIFFUSE_COLOR, ($urandom_range(4) == 0)
                                         ? 48'({$urandom, $urandom})
                                         : rand_triple(16384));
            write_reg(REG_NORMAL_ROW_X, ($urandom_range(3) == 0)
                                        ? 48'({$urandom, $urandom})
                                        : rand_triple(8192));
            write_reg(REG_NORMAL_ROW_Y, ($urandom_range(3) == 0)
                                        ? 48'({$urandom, $urandom})
                                        : rand_triple(8192));
            write_reg(REG_NORMAL_ROW_Z, ($urandom_range(3) == 0)
                                        ? 48'({$urandom, $urandom})
                                        : rand_triple(8192));
            calm = (ph == 0);
            for (int k = 0; k < 100; k++)
            begin
                send_normal(rand_field(), rand_field(), rand_field());
                if (ph == 3 && k == 50)
                begin
                    // hold off the next request until every colour is back
                    in_valid <= 1'b0;
                    while (pending_colours != 0)
                        @(negedge clk);
                end
            end
            calm = 1'b0;
            drain();
        end

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: vertex_lambert_lighting.f
rtl/vll_pkg.sv
rtl/vertex_lambert_lighting.sv
tb/vertex_lambert_lighting_checker.sv
tb/vertex_lambert_lighting_tb.sv
